FILE: src/qews_pkg.sv
// package for the two-channel quadrature encoder window speed block
// payload structs, counter width and configuration register indexes; no dependencies
`default_nettype none
package qews_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int SPEED_WIDTH = 16;
  localparam int WINDOW_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 16;

  localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = WINDOW_WIDTH'(20);

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_MS  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENABLE_ONE = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENABLE_TWO = 2'd2;

  typedef struct packed {
    logic enc1_a;
    logic enc1_b;
    logic enc2_a;
    logic enc2_b;
    logic ms_tick;
  } qews_in_t;

  typedef struct packed {
    logic signed [SPEED_WIDTH-1:0] speed_one;
    logic signed [SPEED_WIDTH-1:0] speed_two;
    logic                          window_done;
  } qews_out_t;

  typedef struct packed {
    logic step;
    logic close;
  } qews_ctl_t;

endpackage
`default_nettype wire

FILE: src/quadrature_encoder_window_speed.sv
// top level of the two-channel quadrature encoder window speed block
// depends on qews_pkg, qews_win and qews_chan
`default_nettype none
// Takes one sample transaction per clock cycle while in_stall is low and returns one
// result per transaction. A sample is captured in an input register, and in the cycle it
// moves on to the result register the tick count, window check and both edge counters
// are updated. out_valid rises once the transaction has moved on to the result register;
// the sustained rate is one transaction per cycle while out_stall is low, and in_stall
// rises only while both the input and result registers are full and out_stall is high.
// Configuration: index 0 window_ms, 1 enable_one, 2 enable_two; other indexes are
// ignored. Write configuration only while the block is idle.
module quadrature_encoder_window_speed (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  qews_pkg::qews_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output qews_pkg::qews_out_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [qews_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [qews_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);
  import qews_pkg::*;

  logic [WINDOW_WIDTH-1:0] window_ms_r;
  logic                    enable_one_r;
  logic                    enable_two_r;

  logic                    s1_valid_r;
  qews_in_t                s1_data_r;
  logic                    out_valid_r;
  qews_out_t               out_r;

  logic                    advance;
  logic                    close;
  qews_ctl_t               ctl;
  logic [SPEED_WIDTH-1:0]  held_one_nxt;
  logic [SPEED_WIDTH-1:0]  held_two_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r  <= WINDOW_RESET;
      enable_one_r <= 1'b1;
      enable_two_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_MS:  window_ms_r  <= cfg_wdata[WINDOW_WIDTH-1:0];
        CFG_ENABLE_ONE: enable_one_r <= cfg_wdata[0];
        CFG_ENABLE_TWO: enable_two_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  qews_win u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .ms_tick   (s1_data_r.ms_tick),
    .window_ms (window_ms_r),
    .close     (close)
  );

  assign ctl.step  = advance;
  assign ctl.close = close;

  qews_chan u_chan_one (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .enc_a    (s1_data_r.enc1_a),
    .enc_b    (s1_data_r.enc1_b),
    .enable   (enable_one_r),
    .held_nxt (held_one_nxt)
  );

  qews_chan u_chan_two (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .enc_a    (s1_data_r.enc2_a),
    .enc_b    (s1_data_r.enc2_b),
    .enable   (enable_two_r),
    .held_nxt (held_two_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.speed_one   <= held_one_nxt;
      out_r.speed_two   <= held_two_nxt;
      out_r.window_done <= close;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after a transaction moved on");

  a_no_stall_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |-> !in_stall)
    else $error("input stalled while the result register is free");

  a_done_tracks_close: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_r.window_done == $past(close)))
    else $error("window flag does not match the window close");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result transaction changed");
`endif

endmodule
`default_nettype wire

FILE: src/qews_win.sv
// millisecond window timer: counts ticks and flags the transaction that closes a window
// depends on qews_pkg
`default_nettype none
module qews_win (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic                               ms_tick,
  input  logic [qews_pkg::WINDOW_WIDTH-1:0]  window_ms,
  output logic                               close
);
  import qews_pkg::*;

  logic [WINDOW_WIDTH-1:0] ms_r;
  logic [WINDOW_WIDTH-1:0] ms_inc;
  logic [WINDOW_WIDTH-1:0] ms_nxt;

  assign ms_inc = ms_tick ? ms_r + WINDOW_WIDTH'(1) : ms_r;
  assign close  = (ms_inc >= window_ms);
  assign ms_nxt = close ? '0 : ms_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r <= '0;
    end else if (step) begin
      ms_r <= ms_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/qews_chan.sv
// one encoder channel: x2 edge counter with window latch of the speed
// depends on qews_pkg
`default_nettype none
module qews_chan (
  input  logic                              clk,
  input  logic                              rst_n,
  input  qews_pkg::qews_ctl_t               ctl,
  input  logic                              enc_a,
  input  logic                              enc_b,
  input  logic                              enable,
  output logic [qews_pkg::SPEED_WIDTH-1:0]  held_nxt
);
  import qews_pkg::*;

  logic                    prev_a_r;
  logic [COUNT_WIDTH-1:0]  count_r;
  logic [COUNT_WIDTH-1:0]  count_base;
  logic [COUNT_WIDTH-1:0]  count_nxt;
  logic [SPEED_WIDTH-1:0]  held_r;
  logic                    edge_hit;

  assign edge_hit   = enable && (enc_a != prev_a_r);
  assign count_base = ctl.close ? '0 : count_r;

  always_comb begin
    count_nxt = count_base;
    if (edge_hit) begin
      if (enc_a != enc_b) begin
        count_nxt = count_base + COUNT_WIDTH'(1);
      end else begin
        count_nxt = count_base - COUNT_WIDTH'(1);
      end
    end
  end

  assign held_nxt = ctl.close ? SPEED_WIDTH'(count_r) : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b0;
      count_r  <= '0;
      held_r   <= '0;
    end else if (ctl.step) begin
      prev_a_r <= enc_a;
      count_r  <= count_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule
`default_nettype wire
